[hdl/murmur64a_stream_hash_macros.svh]
// Assertion macros for the top-level file that checks this block.
`ifndef MURMUR64A_STREAM_HASH_MACROS_SVH
`define MURMUR64A_STREAM_HASH_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, quiet during reset.
`define MUR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on the rising clock, quiet during reset.
`define MUR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/mur_pkg.sv]
`timescale 1ns / 1ps

package mur_pkg;

  // MurmurHash64A multiplier, split for the 32x32 partial products.
  localparam logic [63:0] MUR_MUL    = 64'hc6a4a7935bd1e995;
  localparam logic [31:0] MUR_MUL_LO = MUR_MUL[31:0];
  localparam logic [31:0] MUR_MUL_HI = MUR_MUL[63:32];
  localparam int unsigned MUR_SHIFT  = 47;
  localparam logic [63:0] SEED_RESET = 64'h0000_0000_00c7_0697;

  // Operand choice for the shared multiplier.
  typedef enum logic [2:0] {
    OPA_TOTAL,
    OPA_WORD,
    OPA_K,
    OPA_H,
    OPA_HMIX
  } opa_sel_t;

  // Where a finished product goes.
  typedef enum logic [2:0] {
    WB_NONE,
    WB_SEED,
    WB_K,
    WB_HXOR,
    WB_H,
    WB_FIN
  } wb_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     load;
    logic     mul_start;
    opa_sel_t opa;
    wb_sel_t  wb;
    logic     h_xor_word;
    logic     out_load;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic mul_busy;
    logic mul_done;
  } dp_status_t;

  // The xor-shift step used by both premix and finalization.
  function automatic logic [63:0] mix_shift(input logic [63:0] v);
    mix_shift = v ^ (v >> MUR_SHIFT);
  endfunction

endpackage

[hdl/mur_if.sv]
`timescale 1ns / 1ps

// Message words into the hash unit.
interface mur_word_if;
  logic        valid;
  logic        ready;
  logic [63:0] data;
  logic [3:0]  byte_count;
  logic        first;
  logic        last;
  logic [31:0] total_length;

  modport source (output valid, data, byte_count, first, last, total_length, input ready);
  modport sink   (input valid, data, byte_count, first, last, total_length, output ready);
endinterface

// Finished hash values out of the hash unit.
interface mur_hash_if;
  logic        valid;
  logic        ready;
  logic [63:0] hash_value;

  modport source (output valid, hash_value, input ready);
  modport sink   (input valid, hash_value, output ready);
endinterface

[hdl/mur_mul.sv]
`timescale 1ns / 1ps

module mur_mul
  import mur_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] a,
  output logic        busy,
  output logic        done,
  output logic [63:0] p
);

  // Three partial products give the low 64 bits of a times the multiplier.
  typedef enum logic [1:0] {
    PH_LL,
    PH_LH,
    PH_HL
  } mul_phase_t;

  mul_phase_t  phase;
  logic [63:0] a_reg;
  logic [63:0] acc;
  logic [31:0] op_x;
  logic [31:0] op_y;
  logic [63:0] prod;

  // Operand selection for the single 32x32 multiplier.
  always_comb begin
    unique case (phase)
      PH_LL: begin
        op_x = a_reg[31:0];
        op_y = MUR_MUL_LO;
      end
      PH_LH: begin
        op_x = a_reg[31:0];
        op_y = MUR_MUL_HI;
      end
      PH_HL: begin
        op_x = a_reg[63:32];
        op_y = MUR_MUL_LO;
      end
      default: begin
        op_x = a_reg[31:0];
        op_y = MUR_MUL_LO;
      end
    endcase
  end

  assign prod = 64'(op_x) * 64'(op_y);

  // Sequence the phases and accumulate; the cross terms only touch the upper half.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      phase <= PH_LL;
    end else begin
      done <= 1'b0;
      if (start) begin
        a_reg <= a;
        busy  <= 1'b1;
        phase <= PH_LL;
      end else if (busy) begin
        if (phase == PH_LL) begin
          acc <= prod;
        end else begin
          acc <= acc + {prod[31:0], 32'b0};
        end
        unique case (phase)
          PH_LL:   phase <= PH_LH;
          PH_LH:   phase <= PH_HL;
          PH_HL: begin
            busy <= 1'b0;
            done <= 1'b1;
          end
          default: phase <= PH_LL;
        endcase
      end
    end
  end

  assign p = acc;

endmodule

[hdl/mur_dp.sv]
`timescale 1ns / 1ps

module mur_dp
  import mur_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        seed_we,
  input  logic [63:0] seed_wdata,
  input  logic [63:0] data,
  input  logic [3:0]  byte_count,
  input  logic [31:0] total_length,
  input  dp_cmd_t     cmd,
  output dp_status_t  st,
  output logic [63:0] hash_value
);

  logic [63:0] seed;
  logic [63:0] word;
  logic [31:0] total;
  logic [63:0] h;
  logic [63:0] k;
  logic [63:0] out_hash;
  logic [63:0] byte_mask;
  logic [63:0] mul_a;
  logic [63:0] mul_p;
  logic        mul_busy;
  logic        mul_done;

  // Keep only the valid bytes; counts of eight and above keep the whole word.
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      byte_mask[8*i +: 8] = (byte_count > 4'(i)) ? 8'hff : 8'h00;
    end
  end

  // Operand for the shared multiplier.
  always_comb begin
    unique case (cmd.opa)
      OPA_TOTAL: mul_a = {32'b0, total};
      OPA_WORD:  mul_a = word;
      OPA_K:     mul_a = k;
      OPA_H:     mul_a = h;
      OPA_HMIX:  mul_a = mix_shift(h);
      default:   mul_a = h;
    endcase
  end

  mur_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.mul_start),
    .a     (mul_a),
    .busy  (mul_busy),
    .done  (mul_done),
    .p     (mul_p)
  );

  assign st.mul_busy = mul_busy;
  assign st.mul_done = mul_done;

  // Seed register.
  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= SEED_RESET;
    end else if (seed_we) begin
      seed <= seed_wdata;
    end
  end

  // Input capture, running hash, premix word and the output register.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      word  <= data & byte_mask;
      total <= total_length;
    end
    if (cmd.h_xor_word) begin
      h <= h ^ word;
    end else begin
      unique case (cmd.wb)
        WB_NONE: ;
        WB_SEED: h <= seed ^ mul_p;
        WB_K:    k <= mix_shift(mul_p);
        WB_HXOR: h <= h ^ mul_p;
        WB_H:    h <= mul_p;
        WB_FIN:  h <= mix_shift(mul_p);
        default: ;
      endcase
    end
    if (cmd.out_load) begin
      out_hash <= h;
    end
  end

  assign hash_value = out_hash;

endmodule

[hdl/mur_ctrl.sv]
`timescale 1ns / 1ps

module mur_ctrl
  import mur_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       msg_valid,
  output logic       msg_ready,
  input  logic       first,
  input  logic       last,
  input  logic [3:0] byte_count,
  output logic       out_valid,
  input  logic       out_ready,
  input  dp_status_t st,
  output dp_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEED,
    S_ABSORB,
    S_WMUL,
    S_KMUL,
    S_HMUL,
    S_FIN,
    S_EMIT
  } state_t;

  typedef enum logic [1:0] {
    CLS_NONE,
    CLS_TAIL,
    CLS_FULL
  } count_cls_t;

  state_t     state;
  count_cls_t cls_q;
  count_cls_t cls_in;
  logic       last_q;
  logic       in_msg;
  logic       issued;
  logic       mul_state;

  // Classify the byte count of the incoming word.
  always_comb begin
    priority if (byte_count >= 4'd8) begin
      cls_in = CLS_FULL;
    end else if (byte_count != 4'd0) begin
      cls_in = CLS_TAIL;
    end else begin
      cls_in = CLS_NONE;
    end
  end

  assign msg_ready = (state == S_IDLE);
  assign mul_state = (state == S_SEED) || (state == S_WMUL) || (state == S_KMUL) ||
                     (state == S_HMUL) || (state == S_FIN);

  // Commands for the datapath, decoded from the state and the multiplier status.
  always_comb begin
    cmd            = '0;
    cmd.opa        = OPA_H;
    cmd.wb         = WB_NONE;
    cmd.mul_start  = mul_state && !issued;
    unique case (state)
      S_IDLE:   cmd.load = msg_valid;
      S_SEED: begin
        cmd.opa = OPA_TOTAL;
        if (st.mul_done) cmd.wb = WB_SEED;
      end
      S_ABSORB: cmd.h_xor_word = (cls_q == CLS_TAIL);
      S_WMUL: begin
        cmd.opa = OPA_WORD;
        if (st.mul_done) cmd.wb = WB_K;
      end
      S_KMUL: begin
        cmd.opa = OPA_K;
        if (st.mul_done) cmd.wb = WB_HXOR;
      end
      S_HMUL: begin
        cmd.opa = OPA_H;
        if (st.mul_done) cmd.wb = WB_H;
      end
      S_FIN: begin
        cmd.opa = OPA_HMIX;
        if (st.mul_done) cmd.wb = WB_FIN;
      end
      S_EMIT:   cmd.out_load = !out_valid || out_ready;
      default: ;
    endcase
  end

  // State, message tracking and the output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cls_q     <= CLS_NONE;
      last_q    <= 1'b0;
      in_msg    <= 1'b0;
      issued    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // A started multiply is marked until its done pulse.
      if (mul_state) begin
        if (st.mul_done) begin
          issued <= 1'b0;
        end else if (!issued) begin
          issued <= 1'b1;
        end
      end

      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (msg_valid) begin
            last_q <= last;
            cls_q  <= cls_in;
            // A first word always restarts; other words count only inside a message.
            if (first) begin
              in_msg <= 1'b1;
              state  <= S_SEED;
            end else if (in_msg) begin
              state <= S_ABSORB;
            end
          end
        end
        S_SEED: if (st.mul_done) state <= S_ABSORB;
        S_ABSORB: begin
          unique case (cls_q)
            CLS_FULL: state <= S_WMUL;
            CLS_TAIL: state <= S_HMUL;
            default: begin
              if (last_q) begin
                in_msg <= 1'b0;
                state  <= S_FIN;
              end else begin
                state <= S_IDLE;
              end
            end
          endcase
        end
        S_WMUL: if (st.mul_done) state <= S_KMUL;
        S_KMUL: if (st.mul_done) state <= S_HMUL;
        S_HMUL: begin
          if (st.mul_done) begin
            if (last_q) begin
              in_msg <= 1'b0;
              state  <= S_FIN;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_FIN:  if (st.mul_done) state <= S_EMIT;
        S_EMIT: if (cmd.out_load) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[hdl/murmur64a_stream_hash.sv]
// Each 64-bit product is made in three passes on one shared 32x32 multiplier.
// A full word is premixed and then folded into the hash, a tail word is folded in raw,
// and an ignored word uses no product; a first word is preceded by seeding and a last
// word is followed by finalization.
// Reset (rst, synchronous, active high) idles the block, empties the output
// register and sets the seed to 0xc70697.
`timescale 1ns / 1ps
`include "murmur64a_stream_hash_macros.svh"

module murmur64a_stream_hash
  import mur_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        seed_we,
  input  logic [63:0] seed_wdata,
  mur_word_if.sink    msg,
  mur_hash_if.source  result
);

  dp_cmd_t    cmd;
  dp_status_t st;
  logic       out_valid;

  // Sequencing of seed, absorb and finalize steps.
  mur_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .msg_valid  (msg.valid),
    .msg_ready  (msg.ready),
    .first      (msg.first),
    .last       (msg.last),
    .byte_count (msg.byte_count),
    .out_valid  (out_valid),
    .out_ready  (result.ready),
    .st         (st),
    .cmd        (cmd)
  );

  // Hash state, shared multiplier and output register.
  mur_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .seed_we      (seed_we),
    .seed_wdata   (seed_wdata),
    .data         (msg.data),
    .byte_count   (msg.byte_count),
    .total_length (msg.total_length),
    .cmd          (cmd),
    .st           (st),
    .hash_value   (result.hash_value)
  );

  assign result.valid = out_valid;

  // The multiplier is quiet whenever a new word may be taken.
  `MUR_ASSERT_NOW(a_ready_mul_idle, msg.ready, !st.mul_busy && !st.mul_done, "mul active while ready")
  // A multiply completes in a single-cycle pulse.
  `MUR_ASSERT_NEXT(a_done_pulse, st.mul_done, !st.mul_done, "mul done held")
  // A new multiply is never started on top of a running one.
  `MUR_ASSERT_NOW(a_no_restart, cmd.mul_start, !st.mul_busy, "mul restarted while busy")
  // The output register is only loaded when it is free or being drained.
  `MUR_ASSERT_NOW(a_out_load_free, cmd.out_load, !result.valid || result.ready, "result overwritten")

endmodule

[verif/tb_murmur64a_stream_hash.sv]
`timescale 1ns / 1ps

// Hash constants, kept apart from the design package on purpose.
localparam logic [63:0] HASH_MUL      = 64'hc6a4a7935bd1e995;
localparam int unsigned MIX_SHIFT     = 47;
localparam logic [63:0] SEED_AT_RESET = 64'h0000_0000_00c7_0697;

// One message word as the sender presents it.
typedef struct packed {
  logic [63:0] data;
  logic [3:0]  byte_count;
  logic        first;
  logic        last;
  logic [31:0] total_length;
} hash_word_t;

// Mask that keeps the low count bytes of a word; a full word keeps all of them.
function automatic logic [63:0] low_bytes_mask(int count);
  if (count >= 8) begin
    return '1;
  end
  return (64'd1 << (8 * count)) - 64'd1;
endfunction

// Tracks the running hash of the message in flight and the hashes still owed.
class hash_scoreboard;
  logic [63:0] seed;
  logic [63:0] running_hash;
  bit          in_message;
  logic [63:0] expected_hashes[$];
  int          words_absorbed;
  int          words_ignored;
  int          hashes_checked;
  int          mismatches;

  function new();
    seed           = SEED_AT_RESET;
    running_hash   = '0;
    in_message     = 1'b0;
    words_absorbed = 0;
    words_ignored  = 0;
    hashes_checked = 0;
    mismatches     = 0;
  endfunction

  function logic [63:0] xor_shift(logic [63:0] v);
    return v ^ (v >> MIX_SHIFT);
  endfunction

  // A full word is premixed before it is folded in; a tail word goes in raw.
  function logic [63:0] absorb_word(logic [63:0] h, logic [63:0] data, logic [3:0] count);
    logic [63:0] k;
    if (count >= 4'd8) begin
      k = xor_shift(data * HASH_MUL) * HASH_MUL;
      h = (h ^ k) * HASH_MUL;
    end else if (count != 4'd0) begin
      h = (h ^ (data & low_bytes_mask(count))) * HASH_MUL;
    end
    return h;
  endfunction

  function logic [63:0] finish_hash(logic [63:0] h);
    return xor_shift(xor_shift(h) * HASH_MUL);
  endfunction

  // Notes an accepted word; returns 1 when the block acts on it.
  function bit note_word(hash_word_t w);
    if (w.first) begin
      running_hash = seed ^ ({32'd0, w.total_length} * HASH_MUL);
      in_message   = 1'b1;
    end else if (!in_message) begin
      words_ignored++;
      return 1'b0;
    end
    running_hash = absorb_word(running_hash, w.data, w.byte_count);
    words_absorbed++;
    if (w.last) begin
      expected_hashes.push_back(finish_hash(running_hash));
      in_message = 1'b0;
    end
    return 1'b1;
  endfunction

  function void report(string what);
    mismatches++;
    if (mismatches <= 40) begin
      $display("[%0t] mismatch: %s", $time, what);
    end
  endfunction

  // Compares a delivered hash with the oldest one owed.
  function void check_hash(logic [63:0] got);
    logic [63:0] want;
    if (expected_hashes.size() == 0) begin
      report($sformatf("hash %h delivered with none owed", got));
      return;
    end
    want = expected_hashes.pop_front();
    hashes_checked++;
    if (got !== want) begin
      report($sformatf("hash_value %h, predicted %h", got, want));
    end
  endfunction
endclass

module tb_murmur64a_stream_hash;
  import mur_pkg::*;

  localparam int CYCLE_LIMIT   = 500000;
  localparam int SETTLE_CYCLES = 60;
  localparam int SEGMENT_WORDS = 280;

  logic        clk;
  logic        rst;
  logic        seed_we;
  logic [63:0] seed_wdata;

  mur_word_if msg_if ();
  mur_hash_if hash_if ();

  hash_scoreboard board;
  int send_idle_pct;
  int recv_idle_pct;
  int words_done;
  int seeds_loaded;
  int cycles;

  murmur64a_stream_hash dut (
    .clk        (clk),
    .rst        (rst),
    .seed_we    (seed_we),
    .seed_wdata (seed_wdata),
    .msg        (msg_if),
    .result     (hash_if)
  );

  // Free-running 2 ns clock.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Give up on a hung run.
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles", cycles);
    $display("FAILURE");
    $finish;
  end

  // Hash receiver: checks each delivered hash and stalls at random.
  initial begin
    hash_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && hash_if.valid && hash_if.ready) begin
        board.check_hash(hash_if.hash_value);
      end
      hash_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  function automatic hash_word_t make_word(logic [63:0] data, int count, bit first,
                                           bit last, logic [31:0] total);
    hash_word_t w;
    w.data         = data;
    w.byte_count   = count[3:0];
    w.first        = first;
    w.last         = last;
    w.total_length = total;
    return w;
  endfunction

  // Random word content; unused bytes are zero unless junk is asked for.
  function automatic logic [63:0] word_bytes(int count, bit junk);
    logic [63:0] d;
    d = {$urandom, $urandom};
    return junk ? d : (d & low_bytes_mask(count));
  endfunction

  // Offers one word, possibly after a random gap, and waits for acceptance.
  // Valid stays high after acceptance so back-to-back words need no second drive.
  task automatic send_word(hash_word_t w);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      msg_if.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    msg_if.valid        <= 1'b1;
    msg_if.data         <= w.data;
    msg_if.byte_count   <= w.byte_count;
    msg_if.first        <= w.first;
    msg_if.last         <= w.last;
    msg_if.total_length <= w.total_length;
    do @(posedge clk); while (!msg_if.ready);
    if (board.note_word(w)) begin
      words_done++;
    end
  endtask

  // Stops sending and waits until every owed hash is back and the block is quiet.
  task automatic drain();
    msg_if.valid <= 1'b0;
    while (board.expected_hashes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_seed(logic [63:0] value);
    drain();
    seed_we    <= 1'b1;
    seed_wdata <= value;
    @(posedge clk);
    seed_we    <= 1'b0;
    board.seed = value;
    seeds_loaded++;
  endtask

  // One random message: mostly well formed, the rest stray, cut short or odd words.
  task automatic random_message();
    int kind;
    int nfull;
    int tail;
    int nwords;
    int count;
    logic [31:0] total;
    kind = $urandom_range(0, 99);
    if (kind < 70) begin
      nfull  = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 16) : $urandom_range(0, 5);
      tail   = $urandom_range(0, 7);
      total  = ($urandom_range(0, 7) == 0) ? $urandom : nfull * 8 + tail;
      nwords = nfull + ((tail != 0) ? 1 : 0);
      // A message with no bytes at all is a single empty word.
      if (nwords == 0) begin
        nwords = 1;
      end
      for (int i = 0; i < nwords; i++) begin
        count = (i < nfull) ? 8 : tail;
        send_word(make_word(word_bytes(count, $urandom_range(0, 9) == 0), count,
                            i == 0, i == nwords - 1, total));
      end
    end else if (kind < 80) begin
      // Words without a start flag; ignored unless a message was left open.
      repeat ($urandom_range(1, 3)) begin
        count = $urandom_range(0, 15);
        send_word(make_word(word_bytes(count, 1'b1), count, 1'b0,
                            $urandom_range(0, 1), $urandom));
      end
    end else if (kind < 88) begin
      // A message that never ends; the next start abandons it.
      nwords = $urandom_range(1, 4);
      for (int i = 0; i < nwords; i++) begin
        send_word(make_word(word_bytes(8, 1'b0), 8, i == 0, 1'b0, 8 * nwords));
      end
    end else begin
      // Odd byte counts, including oversized ones, with junk in unused bytes.
      nwords = $urandom_range(1, 6);
      total  = $urandom;
      for (int i = 0; i < nwords; i++) begin
        count = $urandom_range(0, 15);
        send_word(make_word(word_bytes(count, 1'b1), count, i == 0, i == nwords - 1, total));
      end
    end
  endtask

  // Main sequence: reset, directed corner cases, then random segments.
  initial begin
    int target;
    board         = new();
    send_idle_pct = 35;
    recv_idle_pct = 59;
    words_done    = 0;
    seeds_loaded  = 0;
    target        = 0;
    rst                 <= 1'b1;
    seed_we             <= 1'b0;
    seed_wdata          <= '0;
    msg_if.valid        <= 1'b0;
    msg_if.data         <= '0;
    msg_if.byte_count   <= '0;
    msg_if.first        <= 1'b0;
    msg_if.last         <= 1'b0;
    msg_if.total_length <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed words under the seed left by reset.
    send_word(make_word('0, 0, 1'b1, 1'b1, 32'd0));
    send_word(make_word('1, 8, 1'b1, 1'b1, 32'd8));
    send_word(make_word('1, 1, 1'b1, 1'b1, 32'd1));
    send_word(make_word('0, 8, 1'b1, 1'b0, 32'd15));
    send_word(make_word('0, 0, 1'b0, 1'b0, 32'd0));
    send_word(make_word('1, 7, 1'b0, 1'b1, 32'd0));
    send_word(make_word('1, 8, 1'b0, 1'b1, 32'd8));
    send_word(make_word(word_bytes(8, 1'b0), 8, 1'b1, 1'b0, 32'd16));
    send_word(make_word(word_bytes(3, 1'b0), 3, 1'b1, 1'b1, 32'd3));
    send_word(make_word(word_bytes(8, 1'b0), 15, 1'b1, 1'b1, 32'hffff_ffff));
    send_word(make_word(word_bytes(8, 1'b0), 9, 1'b1, 1'b0, 32'd0));
    send_word(make_word(64'h0123_4567_89ab_cdef, 4, 1'b0, 1'b1, 32'd0));

    // Extreme seeds.
    load_seed('0);
    send_word(make_word('0, 8, 1'b1, 1'b1, 32'd0));
    send_word(make_word(word_bytes(8, 1'b0), 8, 1'b1, 1'b0, 32'd13));
    send_word(make_word(word_bytes(5, 1'b0), 5, 1'b0, 1'b1, 32'd0));
    load_seed('1);
    send_word(make_word('0, 0, 1'b1, 1'b1, 32'hffff_ffff));
    send_word(make_word('1, 8, 1'b1, 1'b0, 32'hffff_ffff));
    send_word(make_word('1, 8, 1'b0, 1'b1, 32'd0));

    // Random segments, two per idle pattern, each under a fresh seed.
    for (int mode = 0; mode < 3; mode++) begin
      for (int seg = 0; seg < 2; seg++) begin
        load_seed({$urandom, $urandom});
        send_idle_pct = (mode == 0) ? 35 : (mode == 1) ? 59 : 0;
        recv_idle_pct = (mode == 0) ? 59 : (mode == 1) ? 35 : 0;
        target += SEGMENT_WORDS;
        while (words_done < target) begin
          random_message();
        end
      end
    end
    drain();

    $display("Run covered %0d message words (%0d stray words ignored), %0d hashes, %0d seeds.",
             board.words_absorbed, board.words_ignored, board.hashes_checked, seeds_loaded);
    $display("Idle patterns: sender 35 / receiver 59, then 59 / 35, then none.");
    if (board.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

[files.f]
+incdir+hdl
hdl/mur_pkg.sv
hdl/mur_if.sv
hdl/mur_mul.sv
hdl/mur_dp.sv
hdl/mur_ctrl.sv
hdl/murmur64a_stream_hash.sv
verif/tb_murmur64a_stream_hash.sv
